// ===== rtl/lreb_pkg.sv =====
// Package for the leg reach bound block: fixed-point widths, constants,
// register map, pipeline structs and the angle range reduction function.
// No dependencies.
package lreb_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ADDR_W = 5;
    localparam int REG_IDX_W = 3;
    localparam int ANG_W = 29;      // Q24 angle before range reduction
    localparam int ZW = 28;         // Q24 angle inside the rotator
    localparam int XYW = 28;        // Q24 sine/cosine
    localparam int PW = 45;         // Q24 * Q8.8 product
    localparam int PT_W = 20;       // joint coordinates, Q8.8
    localparam int RAD_W = 32;
    localparam int ROOT_CELLS = 16;
    localparam int REACH_W = 19;

    localparam logic [REG_IDX_W-1:0] REG_TOP      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MID      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BOT      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MIN_BASE = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MIN_KNEE = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MAX_BASE = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_MAX_KNEE = 3'd6;

    localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;
    localparam logic signed [29:0] PI_Q24      = 30'sd52707179;
    localparam logic signed [29:0] TWO_PI_Q24  = 30'sd105414358;
    localparam logic signed [29:0] PI3_Q24     = 30'sd158121537;
    localparam logic signed [29:0] HALF_PI_Q24 = 30'sd26353589;
    localparam logic signed [XYW-1:0] GAIN_Q24 = 28'sd10188014;
    localparam logic signed [PW-1:0] ROUND_Q24 = 45'sd8388608;
    localparam logic signed [20:0] REACH_MAX = 21'sd262143;
    localparam logic signed [20:0] REACH_MIN = -21'sd262144;

    typedef struct packed {
        logic                   vld;
        logic                   want_max;
        logic [1:0]             neg;
        logic                   invalid;
        logic signed [15:0]     elev;
        logic signed [PT_W-1:0] x2;
    } t_side;

    typedef struct packed {
        logic signed [XYW-1:0] x;
        logic signed [XYW-1:0] y;
        logic signed [ZW-1:0]  z;
    } t_rot;

    typedef struct packed {
        logic [RAD_W-1:0] v;
        logic [RAD_W-1:0] res;
    } t_root;

    typedef struct packed {
        logic                 neg;
        logic signed [ZW-1:0] z;
    } t_fold;

    function automatic logic signed [ZW-1:0] atan_q24(input int i);
        logic signed [ZW-1:0] r;
        case (i)
            0:  r = 28'sd13176795;
            1:  r = 28'sd7778716;
            2:  r = 28'sd4110060;
            3:  r = 28'sd2086331;
            4:  r = 28'sd1047214;
            5:  r = 28'sd524117;
            6:  r = 28'sd262123;
            7:  r = 28'sd131069;
            8:  r = 28'sd65536;
            9:  r = 28'sd32768;
            10: r = 28'sd16384;
            11: r = 28'sd8192;
            12: r = 28'sd4096;
            13: r = 28'sd2048;
            14: r = 28'sd1024;
            15: r = 28'sd512;
            16: r = 28'sd256;
            17: r = 28'sd128;
            18: r = 28'sd64;
            19: r = 28'sd32;
            20: r = 28'sd16;
            21: r = 28'sd8;
            22: r = 28'sd4;
            23: r = 28'sd2;
            default: r = '0;
        endcase
        return r;
    endfunction

    // wrap into (-pi, pi], then fold into [-pi/2, pi/2]
    function automatic t_fold fold_angle(input logic signed [ANG_W-1:0] a_in);
        logic signed [29:0] a;
        logic signed [29:0] w;
        t_fold f;
        a = 30'(a_in);
        if (a > PI3_Q24) begin
            w = a - (TWO_PI_Q24 <<< 1);
        end else if (a > PI_Q24) begin
            w = a - TWO_PI_Q24;
        end else if (a <= -PI_Q24) begin
            w = a + TWO_PI_Q24;
        end else begin
            w = a;
        end
        if (w > HALF_PI_Q24) begin
            f.neg = 1'b1;
            f.z = ZW'(w - PI_Q24);
        end else if (w < -HALF_PI_Q24) begin
            f.neg = 1'b1;
            f.z = ZW'(w + PI_Q24);
        end else begin
            f.neg = 1'b0;
            f.z = ZW'(w);
        end
        return f;
    endfunction

endpackage

// ===== rtl/lreb_if.sv =====
// Valid/ready channel interfaces for query and result beats.
// Depends on lreb_pkg.
interface lreb_in_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic signed [15:0] elevation;
    modport source (output valid, output req_type, output elevation, input ready);
    modport sink (input valid, input req_type, input elevation, output ready);
endinterface

interface lreb_out_if;
    import lreb_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [REACH_W-1:0] reach;
    logic                      invalid;
    modport source (output valid, output reach, output invalid, input ready);
    modport sink (input valid, input reach, input invalid, output ready);
endinterface

// ===== rtl/lreb_cordic_cell.sv =====
// One rotation-mode CORDIC iteration for both angle lanes, registered.
// Depends on lreb_pkg.
module lreb_cordic_cell import lreb_pkg::*; #(
    parameter int STAGE = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_side            i_side,
    input  t_rot [1:0]       i_rot,
    output t_side            o_side,
    output t_rot [1:0]       o_rot
);
    localparam logic signed [ZW-1:0] ATAN = atan_q24(STAGE);

    t_side      r_side;
    t_rot [1:0] r_rot;
    t_rot [1:0] n_rot;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (i_rot[l].z >= 0) begin
                n_rot[l].x = i_rot[l].x - (i_rot[l].y >>> STAGE);
                n_rot[l].y = i_rot[l].y + (i_rot[l].x >>> STAGE);
                n_rot[l].z = i_rot[l].z - ATAN;
            end else begin
                n_rot[l].x = i_rot[l].x + (i_rot[l].y >>> STAGE);
                n_rot[l].y = i_rot[l].y - (i_rot[l].x >>> STAGE);
                n_rot[l].z = i_rot[l].z + ATAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else if (i_en) begin
            r_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot <= n_rot;
        end
    end

    assign o_side = r_side;
    assign o_rot  = r_rot;
endmodule

// ===== rtl/lreb_sqrt_cell.sv =====
// One bit step of the restoring integer square root, registered.
// Depends on lreb_pkg.
module lreb_sqrt_cell import lreb_pkg::*; #(
    parameter int BIT_POS = 30
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_side i_side,
    input  t_root i_root,
    output t_side o_side,
    output t_root o_root
);
    localparam logic [RAD_W:0] BITV = (RAD_W+1)'(1) << BIT_POS;

    t_side        r_side;
    t_root        r_root;
    t_root        n_root;
    logic [RAD_W:0] trial;

    always_comb begin
        trial = {1'b0, i_root.res} + BITV;
        if ({1'b0, i_root.v} >= trial) begin
            n_root.v   = RAD_W'({1'b0, i_root.v} - trial);
            n_root.res = (i_root.res >> 1) + RAD_W'(BITV);
        end else begin
            n_root.v   = i_root.v;
            n_root.res = i_root.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else if (i_en) begin
            r_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_root <= n_root;
        end
    end

    assign o_side = r_side;
    assign o_root = r_root;
endmodule

// ===== rtl/leg_reach_extension_bound.sv =====
// Leg reach bound: one query per cycle while the output is not held. Stages
// in order: range reduction 2, rotator chain CORDIC_STAGES, scaling and
// radicand 4, root chain 16, output register 1. The whole pipeline advances
// together and holds only while a result waits at the output. Depends on
// lreb_pkg, lreb_if, lreb_cordic_cell and lreb_sqrt_cell.
module leg_reach_extension_bound import lreb_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lreb_in_if.sink           i_req,
    lreb_out_if.source        o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    logic [15:0] r_top, r_mid, r_bot;
    logic [15:0] r_min_base, r_min_knee, r_max_base, r_max_knee;
    logic [REG_IDX_W-1:0] w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= '0; r_mid <= '0; r_bot <= '0;
            r_min_base <= '0; r_min_knee <= '0; r_max_base <= '0; r_max_knee <= '0;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_TOP:      r_top      <= pwdata[15:0];
                REG_MID:      r_mid      <= pwdata[15:0];
                REG_BOT:      r_bot      <= pwdata[15:0];
                REG_MIN_BASE: r_min_base <= pwdata[15:0];
                REG_MIN_KNEE: r_min_knee <= pwdata[15:0];
                REG_MAX_BASE: r_max_base <= pwdata[15:0];
                REG_MAX_KNEE: r_max_knee <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_TOP:      prdata = {16'd0, r_top};
            REG_MID:      prdata = {16'd0, r_mid};
            REG_BOT:      prdata = {16'd0, r_bot};
            REG_MIN_BASE: prdata = {16'd0, r_min_base};
            REG_MIN_KNEE: prdata = {16'd0, r_min_knee};
            REG_MAX_BASE: prdata = {16'd0, r_max_base};
            REG_MAX_KNEE: prdata = {16'd0, r_max_knee};
            default:      prdata = '0;
        endcase
    end

    logic w_adv;
    logic r_out_vld;
    assign w_adv       = !r_out_vld || o_res.ready;
    assign i_req.ready = w_adv;

    // stage 0: joint angles from horizontal, Q24
    t_side r_s0;
    logic signed [ANG_W-1:0] r_t1, r_t2;
    logic signed [17:0] w_t1, w_t2;
    always_comb begin
        w_t1 = HALF_PI_Q13 - 18'($signed(i_req.req_type ? r_max_base : r_min_base));
        w_t2 = w_t1 - 18'($signed(i_req.req_type ? r_max_knee : r_min_knee));
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0 <= '0;
        end else if (w_adv) begin
            r_s0.vld      <= i_req.valid;
            r_s0.want_max <= i_req.req_type;
            r_s0.elev     <= i_req.elevation;
            r_s0.neg      <= '0;
            r_s0.invalid  <= 1'b0;
            r_s0.x2       <= '0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t1 <= ANG_W'(w_t1) <<< 11;
            r_t2 <= ANG_W'(w_t2) <<< 11;
        end
    end

    // stage 1: range reduction into the rotator input
    t_side      w_side [CORDIC_STAGES+1];
    t_rot [1:0] w_rot  [CORDIC_STAGES+1];
    t_side      r_s1;
    t_side      n_s1;
    t_rot [1:0] r_rot1;
    t_fold      w_f1, w_f2;
    assign w_f1 = fold_angle(r_t1);
    assign w_f2 = fold_angle(r_t2);
    always_comb begin
        n_s1     = r_s0;
        n_s1.neg = {w_f2.neg, w_f1.neg};
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else if (w_adv) begin
            r_s1 <= n_s1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rot1[0] <= '{x: GAIN_Q24, y: '0, z: w_f1.z};
            r_rot1[1] <= '{x: GAIN_Q24, y: '0, z: w_f2.z};
        end
    end
    assign w_side[0] = r_s1;
    assign w_rot[0]  = r_rot1;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
        lreb_cordic_cell #(.STAGE(g)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv),
            .i_side(w_side[g]), .i_rot(w_rot[g]),
            .o_side(w_side[g+1]), .o_rot(w_rot[g+1])
        );
    end

    // stage M: products with the segment lengths
    t_side r_sm;
    logic signed [PW-1:0] r_p [4];
    logic signed [XYW-1:0] w_c1, w_s1, w_c2, w_s2;
    t_side w_cs;
    t_rot [1:0] w_cr;
    assign w_cs = w_side[CORDIC_STAGES];
    assign w_cr = w_rot[CORDIC_STAGES];
    assign w_c1 = w_cs.neg[0] ? -w_cr[0].x : w_cr[0].x;
    assign w_s1 = w_cs.neg[0] ? -w_cr[0].y : w_cr[0].y;
    assign w_c2 = w_cs.neg[1] ? -w_cr[1].x : w_cr[1].x;
    assign w_s2 = w_cs.neg[1] ? -w_cr[1].y : w_cr[1].y;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sm <= '0;
        end else if (w_adv) begin
            r_sm <= w_cs;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p[0] <= PW'(w_c1) * PW'($signed({1'b0, r_top}));
            r_p[1] <= PW'(w_c2) * PW'($signed({1'b0, r_mid}));
            r_p[2] <= PW'(w_s1) * PW'($signed({1'b0, r_top}));
            r_p[3] <= PW'(w_s2) * PW'($signed({1'b0, r_mid}));
        end
    end

    // stage S: joint coordinates
    t_side r_ss;
    t_side n_ss;
    logic signed [PT_W-1:0] r_y2;
    logic signed [PW-1:0] w_q [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_q[k] = (r_p[k] + ROUND_Q24) >>> 24;
        end
    end
    always_comb begin
        n_ss    = r_sm;
        n_ss.x2 = PT_W'(w_q[0]) + PT_W'(w_q[1]);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ss <= '0;
        end else if (w_adv) begin
            r_ss <= n_ss;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_y2 <= PT_W'(r_sm.elev) + PT_W'(w_q[2]) + PT_W'(w_q[3]);
        end
    end

    // stage Q: squares
    t_side r_sq;
    logic signed [2*PT_W-1:0] r_y2sq;
    logic [RAD_W-1:0] r_bot2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq <= '0;
        end else if (w_adv) begin
            r_sq <= r_ss;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_y2sq <= r_y2 * r_y2;
            r_bot2 <= r_bot * r_bot;
        end
    end

    // stage R: radicand
    t_side r_sr;
    t_side n_sr;
    t_root r_rad;
    logic signed [RAD_W+8:0] w_rad;
    assign w_rad = $signed({9'd0, r_bot2}) - (RAD_W+9)'(r_y2sq);
    always_comb begin
        n_sr         = r_sq;
        n_sr.invalid = w_rad[RAD_W+8];
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sr <= '0;
        end else if (w_adv) begin
            r_sr <= n_sr;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rad.v   <= w_rad[RAD_W+8] ? '0 : w_rad[RAD_W-1:0];
            r_rad.res <= '0;
        end
    end

    t_side q_side [ROOT_CELLS+1];
    t_root q_root [ROOT_CELLS+1];
    assign q_side[0] = r_sr;
    assign q_root[0] = r_rad;
    for (genvar j = 0; j < ROOT_CELLS; j++) begin : g_root
        lreb_sqrt_cell #(.BIT_POS(RAD_W - 2 - 2*j)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv),
            .i_side(q_side[j]), .i_root(q_root[j]),
            .o_side(q_side[j+1]), .o_root(q_root[j+1])
        );
    end

    // output register
    t_side w_fs;
    logic signed [20:0] w_sum, w_sat;
    logic signed [20:0] w_r;
    logic signed [REACH_W-1:0] r_reach;
    logic r_invalid;
    assign w_fs = q_side[ROOT_CELLS];
    assign w_r  = $signed({5'd0, q_root[ROOT_CELLS].res[15:0]});
    always_comb begin
        w_sum = w_fs.want_max ? 21'(w_fs.x2) + w_r : 21'(w_fs.x2) - w_r;
        if (w_sum > REACH_MAX) begin
            w_sat = REACH_MAX;
        end else if (w_sum < REACH_MIN) begin
            w_sat = REACH_MIN;
        end else begin
            w_sat = w_sum;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_fs.vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_invalid <= w_fs.invalid;
            r_reach   <= w_fs.invalid ? '0 : w_sat[REACH_W-1:0];
        end
    end
    assign o_res.valid   = r_out_vld;
    assign o_res.reach   = r_reach;
    assign o_res.invalid = r_invalid;

    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.invalid |-> o_res.reach == '0)
        else $error("invalid result with nonzero reach");
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> r_s0.vld)
        else $error("accepted beat missing in first stage");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_s0) && $stable(r_sr))
        else $error("pipeline moved during stall");
endmodule
